// ===== design/deadline_priority_queue_core_assert.svh =====
// Assertion macros for the deadline priority queue core.
`ifndef DEADLINE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define DEADLINE_PRIORITY_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define DPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DPQ_ASSERT_IMP(lbl, ante, cons, msg)
`define DPQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/dpq_pkg.sv =====
// Shared types, codes and constants of the deadline priority queue.
`default_nettype none

package dpq_pkg;

  localparam int DPQ_CAPACITY = 16;

  localparam int OP_W      = 2;
  localparam int DL_W      = 16;
  localparam int KIND_W    = 3;
  localparam int PL_W      = 32;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERDUE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [DL_W-1:0]   deadline;
    logic [KIND_W-1:0] kind;
    logic [PL_W-1:0]   payload;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/dpq_cell.sv =====
// One slot of the sorted chain: compares, shifts right on insert, left on pop.
`default_nettype none

module dpq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dpq_pkg::cell_ctl_t ctl,
  input  wire dpq_pkg::entry_t    left_entry,
  input  wire logic               left_valid,
  input  wire logic               left_ge,
  input  wire dpq_pkg::entry_t    right_entry,
  input  wire logic               right_valid,
  output dpq_pkg::entry_t         entry,
  output logic                    valid,
  output logic                    ge
);
  import dpq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;

  // Sorted chain: ge is set on a contiguous run ending at the last valid slot.
  assign ge = valid_r && (entry_r.deadline >= ctl.new_entry.deadline);

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.enq) begin
      if (left_ge) begin
        entry_nxt = left_entry;
        valid_nxt = 1'b1;
      end else if (left_valid && (ge || !valid_r)) begin
        entry_nxt = ctl.new_entry;
        valid_nxt = 1'b1;
      end
    end else if (ctl.deq) begin
      entry_nxt = right_entry;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

// ===== design/deadline_priority_queue_core.sv =====
// Top level of the deadline priority queue: chain of sorted cells and result register.
`default_nettype none
`include "deadline_priority_queue_core_assert.svh"

// A command is taken whenever start is high and busy is low; busy is high
// while reset is applied, is cleared once reset is released, then stays
// low. Every command, enqueue,
// dequeue, peek or the unused code, gives exactly one result, shown with
// out_strobe for one cycle, the cycle after the command's transfer. The
// receiver cannot stall that result, and none is needed: a command may follow
// in every cycle, since each slot of the queue is a cell that compares its
// deadline with the new one and shifts in the same cycle, so a 16-bit compare
// (per cell, and against today for the enqueue control) plus the cell's
// four-way select (hold, shift in from either side, or take the new task)
// sets the clock rate. The queue keeps
// CAPACITY tasks, earliest deadline first, equal deadlines last in first out.
module deadline_priority_queue_core #(
  parameter int CAPACITY = dpq_pkg::DPQ_CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [dpq_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [dpq_pkg::DL_W-1:0]      in_task_deadline,
  input  wire logic [dpq_pkg::KIND_W-1:0]    in_task_kind,
  input  wire logic [dpq_pkg::PL_W-1:0]      in_task_payload,
  output logic                               out_strobe,
  output logic [dpq_pkg::ST_W-1:0]           out_status,
  output logic [dpq_pkg::DL_W-1:0]           out_deadline,
  output logic [dpq_pkg::KIND_W-1:0]         out_kind,
  output logic [dpq_pkg::PL_W-1:0]           out_payload,
  output logic [dpq_pkg::CNT_OUT_W-1:0]      out_entry_count,
  output logic                               out_is_empty,
  output logic [dpq_pkg::DL_W-1:0]           out_today
);
  import dpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic             busy_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [DL_W-1:0]  today_r, today_nxt;

  logic             strobe_r;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic [DL_W-1:0]  rdl_r, rdl_nxt;
  logic [KIND_W-1:0] rkind_r, rkind_nxt;
  logic [PL_W-1:0]  rpl_r, rpl_nxt;

  logic             accept;
  logic             empty, full;
  logic             do_enq, do_deq;
  cell_ctl_t        ctl;

  entry_t               cell_entry [CAPACITY];
  logic [CAPACITY-1:0]  cell_valid;
  logic [CAPACITY-1:0]  cell_ge;
  entry_t               left_entry [CAPACITY];
  logic [CAPACITY-1:0]  left_valid;
  logic [CAPACITY-1:0]  left_ge;
  entry_t               right_entry [CAPACITY];
  logic [CAPACITY-1:0]  right_valid;

  assign busy   = busy_r;
  assign accept = start && !busy_r;
  assign empty  = (count_r == '0);
  assign full   = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    status_nxt = ST_OK;
    rdl_nxt    = '0;
    rkind_nxt  = '0;
    rpl_nxt    = '0;
    count_nxt  = count_r;
    today_nxt  = today_r;
    do_enq     = 1'b0;
    do_deq     = 1'b0;
    unique case (in_opcode)
      OP_ENQ: begin
        if (in_task_deadline < today_r) begin
          status_nxt = ST_OVERDUE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          do_enq    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_DEQ: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          do_deq    = 1'b1;
          rkind_nxt = cell_entry[0].kind;
          rpl_nxt   = cell_entry[0].payload;
          today_nxt = cell_entry[0].deadline;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rdl_nxt   = cell_entry[0].deadline;
          rkind_nxt = cell_entry[0].kind;
          rpl_nxt   = cell_entry[0].payload;
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.enq                = accept && do_enq;
  assign ctl.deq                = accept && do_deq;
  assign ctl.new_entry.deadline = in_task_deadline;
  assign ctl.new_entry.kind     = in_task_kind;
  assign ctl.new_entry.payload  = in_task_payload;

  // Neighbour wiring; the head sees an always-valid, never-later left side.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        left_entry[i] = ctl.new_entry;
        left_valid[i] = 1'b1;
        left_ge[i]    = 1'b0;
      end else begin
        left_entry[i] = cell_entry[i-1];
        left_valid[i] = cell_valid[i-1];
        left_ge[i]    = cell_ge[i-1];
      end
      if (i == CAPACITY - 1) begin
        right_entry[i] = '0;
        right_valid[i] = 1'b0;
      end else begin
        right_entry[i] = cell_entry[i+1];
        right_valid[i] = cell_valid[i+1];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    dpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_entry  (left_entry[g]),
      .left_valid  (left_valid[g]),
      .left_ge     (left_ge[g]),
      .right_entry (right_entry[g]),
      .right_valid (right_valid[g]),
      .entry       (cell_entry[g]),
      .valid       (cell_valid[g]),
      .ge          (cell_ge[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      strobe_r <= 1'b0;
      count_r  <= '0;
      today_r  <= '0;
    end else begin
      busy_r   <= 1'b0;
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
        today_r <= today_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rdl_r    <= rdl_nxt;
      rkind_r  <= rkind_nxt;
      rpl_r    <= rpl_nxt;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_deadline    = rdl_r;
  assign out_kind        = rkind_r;
  assign out_payload     = rpl_r;
  assign out_entry_count = CNT_OUT_W'(count_r);
  assign out_is_empty    = empty;
  assign out_today       = today_r;

  `DPQ_ASSERT_IMP(a_count_front, 1'b1, empty == !cell_valid[0], "count and head slot disagree")
  `DPQ_ASSERT_IMP(a_count_tail, 1'b1, full == cell_valid[CAPACITY-1], "count and tail slot disagree")
  `DPQ_ASSERT_IMP(a_valid_packed, 1'b1, (cell_valid & (cell_valid + 1'b1)) == '0, "gap in chain")
  `DPQ_ASSERT_NXT(a_deq_count, accept && (in_opcode == OP_DEQ) && !empty, count_r == $past(count_r) - 1'b1, "dequeue count")
  `DPQ_ASSERT_NXT(a_strobe, 1'b1, out_strobe == $past(accept), "strobe not tied to transfer")

  for (genvar k = 0; k < CAPACITY - 1; k++) begin : g_sorted
    `DPQ_ASSERT_IMP(a_sorted, cell_valid[k+1], cell_entry[k].deadline <= cell_entry[k+1].deadline, "chain out of order")
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the deadline priority queue core: directed and random commands checked per result.
module testbench;
  import dpq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int GAP_MAX   = 4;
  localparam int BURST_LEN = 20;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [DL_W-1:0]      deadline;
    logic [KIND_W-1:0]    kind;
    logic [PL_W-1:0]      payload;
    logic [CNT_OUT_W-1:0] count;
    logic                 is_empty;
    logic [DL_W-1:0]      today;
  } queue_result_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_opcode = '0;
  logic [DL_W-1:0]      in_task_deadline = '0;
  logic [KIND_W-1:0]    in_task_kind = '0;
  logic [PL_W-1:0]      in_task_payload = '0;
  logic                 out_strobe;
  logic [ST_W-1:0]      out_status;
  logic [DL_W-1:0]      out_deadline;
  logic [KIND_W-1:0]    out_kind;
  logic [PL_W-1:0]      out_payload;
  logic [CNT_OUT_W-1:0] out_entry_count;
  logic                 out_is_empty;
  logic [DL_W-1:0]      out_today;

  // Model of the queue: front of the list is the earliest deadline
  entry_t          model_slots[$];
  logic [DL_W-1:0] model_today = '0;
  queue_result_t   pending_results[$];
  int              failures = 0;

  deadline_priority_queue_core #(
    .CAPACITY(DPQ_CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_task_deadline(in_task_deadline),
    .in_task_kind(in_task_kind),
    .in_task_payload(in_task_payload),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_deadline(out_deadline),
    .out_kind(out_kind),
    .out_payload(out_payload),
    .out_entry_count(out_entry_count),
    .out_is_empty(out_is_empty),
    .out_today(out_today)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #200000;
    $display("testbench: errors");
    $finish;
  end

  task automatic predict_queue_op(input logic [OP_W-1:0] op, input entry_t item,
                                  output queue_result_t r);
    int     pos;
    entry_t front;
    r = '0;
    case (op)
      OP_ENQ: begin
        // overdue takes precedence over full
        if (item.deadline < model_today) begin
          r.status = ST_OVERDUE;
        end else if (model_slots.size() >= DPQ_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < model_slots.size() && model_slots[pos].deadline < item.deadline) pos++;
          model_slots.insert(pos, item);
          r.status = ST_OK;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (model_slots.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          front = model_slots[0];
          r.status = ST_OK;
          r.kind = front.kind;
          r.payload = front.payload;
          if (op == OP_PEEK) begin
            r.deadline = front.deadline;
          end else begin
            // dequeue reports a zero deadline but moves the day on
            model_slots.delete(0);
            model_today = front.deadline;
          end
        end
      end
      default: r.status = ST_OK;
    endcase
    r.count = CNT_OUT_W'(model_slots.size());
    r.is_empty = (model_slots.size() == 0);
    r.today = model_today;
  endtask

  task automatic check_field(input string name, input logic [PL_W-1:0] expd,
                             input logic [PL_W-1:0] act);
    if (act !== expd) begin
      $error("%s: expected %0h, got %0h", name, expd, act);
      failures++;
    end
  endtask

  // Outputs are read at the edge that ends the strobe cycle, before the core updates them
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("out_strobe with no command outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", PL_W'(want.status), PL_W'(out_status));
        check_field("deadline", PL_W'(want.deadline), PL_W'(out_deadline));
        check_field("kind", PL_W'(want.kind), PL_W'(out_kind));
        check_field("payload", want.payload, out_payload);
        check_field("entry_count", PL_W'(want.count), PL_W'(out_entry_count));
        check_field("is_empty", PL_W'(want.is_empty), PL_W'(out_is_empty));
        check_field("today", PL_W'(want.today), PL_W'(out_today));
      end
    end
  end

  // Called at a rising edge; returns at the edge of the transfer with start still high
  task automatic issue_command(input logic [OP_W-1:0] op, input logic [DL_W-1:0] dl,
                               input logic [KIND_W-1:0] kd, input logic [PL_W-1:0] pl);
    entry_t        item;
    queue_result_t r;
    start <= 1'b1;
    in_opcode <= op;
    in_task_deadline <= dl;
    in_task_kind <= kd;
    in_task_payload <= pl;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    item.deadline = dl;
    item.kind = kd;
    item.payload = pl;
    predict_queue_op(op, item, r);
    pending_results.push_back(r);
  endtask

  task automatic idle_sender(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
  endtask

  function automatic logic [DL_W-1:0] pick_deadline();
    int unsigned roll;
    int unsigned later;
    roll = $urandom_range(99);
    if (roll < 15) return model_today;
    if (roll < 21) return DL_W'($urandom_range(65535));
    if (roll < 35 && model_slots.size() != 0)
      return model_slots[$urandom_range(model_slots.size() - 1)].deadline;
    if (roll < 42 && model_today != '0) return model_today - 1'b1;
    later = model_today + $urandom_range(1, 60);
    return (later > 16'hFFFF) ? 16'hFFFF : DL_W'(later);
  endfunction

  task automatic test_empty_queue();
    issue_command(OP_PEEK, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
    issue_command(OP_DEQ, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
    issue_command(OP_UNUSED, 16'h1234, 3'd5, 32'hDEAD_BEEF);
  endtask

  task automatic test_ordering_and_ties();
    issue_command(OP_ENQ, 16'd0, 3'd0, 32'h0);
    issue_command(OP_ENQ, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
    // two equal deadlines: the later one must come out first
    issue_command(OP_ENQ, 16'd100, 3'd3, 32'hA5A5_A5A5);
    issue_command(OP_ENQ, 16'd100, 3'd4, 32'h5A5A_5A5A);
    issue_command(OP_PEEK, 16'd0, 3'd0, 32'h0);
    issue_command(OP_DEQ, 16'd0, 3'd0, 32'h0);
    issue_command(OP_DEQ, 16'd0, 3'd0, 32'h0);
    issue_command(OP_PEEK, 16'd0, 3'd0, 32'h0);
  endtask

  task automatic test_overdue_and_full();
    issue_command(OP_ENQ, model_today - 1'b1, 3'd2, 32'h1111_1111);
    issue_command(OP_ENQ, model_today, 3'd6, 32'h2222_2222);
    while (model_slots.size() < DPQ_CAPACITY)
      issue_command(OP_ENQ, model_today + DL_W'($urandom_range(500)), KIND_W'($urandom),
                    $urandom);
    issue_command(OP_ENQ, 16'd5000, 3'd1, 32'h3333_3333);
    issue_command(OP_ENQ, 16'd50, 3'd1, 32'h4444_4444);
    issue_command(OP_PEEK, 16'd0, 3'd0, 32'h0);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int items);
    int unsigned     roll;
    bit              fill_mode;
    logic [OP_W-1:0] op;
    fill_mode = 1'b1;
    for (int n = 0; n < items; n++) begin
      // bursts that mostly fill or mostly drain, so both full and empty are reached
      if (n % BURST_LEN == 0) fill_mode = $urandom_range(1);
      roll = $urandom_range(99);
      if (roll < 4) op = OP_UNUSED;
      else if (roll < 14) op = OP_PEEK;
      else if (roll < (fill_mode ? 74 : 39)) op = OP_ENQ;
      else op = OP_DEQ;
      issue_command(op, pick_deadline(), KIND_W'($urandom), $urandom);
      idle_sender(gap_pct);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_ordering_and_ties();
    test_overdue_and_full();
    test_random_traffic(0, 175);
    test_random_traffic(77, 175);
    test_random_traffic(0, 175);
    test_random_traffic(29, 175);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/dpq_pkg.sv
design/dpq_cell.sv
design/deadline_priority_queue_core.sv
test/testbench.sv
